>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define SFR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// When trig holds, cond must hold at the next clock edge.
`define SFR_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> design/sfr_pkg.sv
// ---------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the serial frame receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  localparam int unsigned ByteW = 8;

  // configuration register indexes
  localparam int unsigned CfgAddrW = 1;
  localparam logic [CfgAddrW-1:0] CFG_HEADER_FIRST  = 1'b0;
  localparam logic [CfgAddrW-1:0] CFG_HEADER_SECOND = 1'b1;

  localparam logic [ByteW-1:0] HeaderFirstRst  = 8'hAA;
  localparam logic [ByteW-1:0] HeaderSecondRst = 8'h55;

  // length byte counts header, length and checksum bytes
  localparam logic [ByteW-1:0] LenOverhead = 8'd4;
  localparam logic [ByteW-1:0] LenMin      = 8'd5;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_LENERR  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  data_byte;
    logic [ByteW-1:0]  byte_index;
  } sfr_res_t;

endpackage

`default_nettype wire

>>> design/sfr_in_reg.sv
// ---------------------------------------------------------------------------
// sfr_in_reg
// Input register: holds one received byte until the parser consumes it.
// ---------------------------------------------------------------------------
`default_nettype none

module sfr_in_reg
  import sfr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] in_byte_i,
  output logic                  byte_valid_o,
  output logic [ByteW-1:0]      byte_o,
  input  wire logic             byte_take_i
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;

  assign in_ready_o = !valid_q || byte_take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

`default_nettype wire

>>> design/sfr_parser.sv
// ---------------------------------------------------------------------------
// sfr_parser
// Frame state machine, header registers and checksum accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

module sfr_parser
  import sfr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [ByteW-1:0]    cfg_wdata_i,
  input  wire logic                byte_valid_i,
  input  wire logic [ByteW-1:0]    byte_i,
  output logic                     byte_take_o,
  input  wire logic                res_free_i,
  output logic                     res_valid_o,
  output sfr_res_t                 res_o
);

  `include "assert_macros.svh"

  localparam logic [2:0] PH_HEAD1   = 3'd0;
  localparam logic [2:0] PH_HEAD2   = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CSUM    = 3'd4;

  logic [ByteW-1:0] hdr_first_q, hdr_second_q;
  logic [2:0]       phase_q, phase_d;
  logic [ByteW-1:0] left_q, left_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] pos_q, pos_d;
  logic             has_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= HeaderFirstRst;
      hdr_second_q <= HeaderSecondRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_HEADER_FIRST:  hdr_first_q  <= cfg_wdata_i;
        CFG_HEADER_SECOND: hdr_second_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d          = phase_q;
    left_d           = left_q;
    sum_d            = sum_q;
    pos_d            = pos_q;
    has_res          = 1'b0;
    res_o.kind       = KIND_PAYLOAD;
    res_o.data_byte  = byte_i;
    res_o.byte_index = '0;
    case (phase_q)
      PH_HEAD2: begin
        if (byte_i == hdr_second_q) begin
          sum_d   = sum_q + byte_i;
          phase_d = PH_LEN;
        end else begin
          phase_d = PH_HEAD1;
        end
      end
      PH_LEN: begin
        if (byte_i < LenMin) begin
          has_res    = 1'b1;
          res_o.kind = KIND_LENERR;
          phase_d    = PH_HEAD1;
        end else begin
          sum_d   = sum_q + byte_i;
          left_d  = byte_i - LenOverhead;
          pos_d   = '0;
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        has_res          = 1'b1;
        res_o.byte_index = pos_q;
        sum_d            = sum_q + byte_i;
        pos_d            = pos_q + 8'd1;
        left_d           = left_q - 8'd1;
        if (left_q == 8'd1) begin
          phase_d = PH_CSUM;
        end
      end
      PH_CSUM: begin
        has_res    = 1'b1;
        res_o.kind = (byte_i == sum_q) ? KIND_GOOD : KIND_BAD;
        phase_d    = PH_HEAD1;
      end
      default: begin
        // unused codes hunt like the first header phase
        if (byte_i == hdr_first_q) begin
          sum_d   = byte_i;
          phase_d = PH_HEAD2;
        end else begin
          phase_d = PH_HEAD1;
        end
      end
    endcase
  end

  // a byte with a result waits for a free output slot
  assign byte_take_o = byte_valid_i && (!has_res || res_free_i);
  assign res_valid_o = byte_take_o && has_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD1;
      left_q  <= '0;
      sum_q   <= '0;
      pos_q   <= '0;
    end else if (byte_take_o) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      sum_q   <= sum_d;
      pos_q   <= pos_d;
    end
  end

  `SFR_ASSERT_NEXT(a_len_ok, byte_take_o && phase_q == PH_LEN && byte_i >= LenMin,
    phase_q == PH_PAYLOAD && left_q != '0, "valid length did not start payload")
  `SFR_ASSERT_NEXT(a_sum_seed, byte_take_o && phase_q == PH_HEAD1 && byte_i == hdr_first_q,
    sum_q == $past(byte_i), "checksum not seeded by first header byte")
  `SFR_ASSERT(a_payload_left, phase_q != PH_PAYLOAD || left_q != '0,
    "payload phase with no bytes left")

endmodule

`default_nettype wire

>>> design/sfr_out_reg.sv
// ---------------------------------------------------------------------------
// sfr_out_reg
// Result register: holds one result request until the sink takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module sfr_out_reg
  import sfr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     res_valid_i,
  input  wire sfr_res_t res_i,
  output logic          res_free_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output sfr_res_t      out_o
);

  logic     valid_q, valid_d;
  sfr_res_t res_q;

  assign res_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

`default_nettype wire

>>> design/serial_frame_receiver_unit.sv
// ---------------------------------------------------------------------------
// serial_frame_receiver_unit
// Byte stream deframer: two sync bytes, length, payload, additive checksum.
// ---------------------------------------------------------------------------
// Channel      Dir  Payload
// s_axis       in   tdata[7:0] rx_byte
// m_axis       out  tdata[7:0] data_byte, [15:8] byte_index; tuser[1:0] kind
// cfg          in   index 0 header_first, 1 header_second; no read-back
//
// One byte per cycle while the output keeps up; a byte enters the input
// register, is parsed from there and its result lands in the output register.
// Reset (async, active low) clears all control state and loads the sync
// byte defaults; a stalled output holds back only bytes that make a result.
// ---------------------------------------------------------------------------
`default_nettype none

module serial_frame_receiver_unit
  import sfr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [ByteW-1:0]    cfg_wdata_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,  // [7:0] rx_byte
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [15:0]              m_axis_tdata,  // [7:0] data_byte, [15:8] byte_index
  output logic [1:0]               m_axis_tuser   // [1:0] kind
);

  `include "assert_macros.svh"

  logic             byte_valid, byte_take, res_valid, res_free;
  logic [ByteW-1:0] byte_val;
  sfr_res_t         res, out_res;

  sfr_in_reg u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .byte_valid_o (byte_valid),
    .byte_o       (byte_val),
    .byte_take_i  (byte_take)
  );

  sfr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .byte_valid_i (byte_valid),
    .byte_i       (byte_val),
    .byte_take_o  (byte_take),
    .res_free_i   (res_free),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  sfr_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_free_o  (res_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out_res)
  );

  assign m_axis_tdata = {out_res.byte_index, out_res.data_byte};
  assign m_axis_tuser = out_res.kind;

  `SFR_ASSERT(a_end_index, !m_axis_tvalid || m_axis_tuser == KIND_PAYLOAD ||
    m_axis_tdata[15:8] == 8'd0, "frame end or length error with nonzero index")
  `SFR_ASSERT_NEXT(a_res_lands, res_valid, m_axis_tvalid,
    "parsed result did not reach the output register")
  `SFR_ASSERT_NEXT(a_no_drop, m_axis_tvalid && !m_axis_tready && !res_valid,
    m_axis_tvalid && $stable(m_axis_tdata), "held result lost or changed")

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: serial_frame_receiver_unit regression
// Streams byte sequences through the deframer under random source gaps and
// sink stalls, predicts every payload/end/length-error result in the bench
// and compares each one field by field as it leaves the block.
// ---------------------------------------------------------------------------
module tb;
  import sfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int          PHASE_BYTES  = 290;
  localparam int          SETTLE_CYC   = 4;      // > input-to-result latency
  localparam int          LONG_HOLD    = 400;

  typedef enum logic [2:0] {
    SEEK_SYNC0, SEEK_SYNC1, TAKE_LEN, TAKE_BODY, TAKE_SUM
  } parse_st_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = CFG_HEADER_FIRST;
  logic [ByteW-1:0]    cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // [7:0] rx_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;        // [7:0] data_byte, [15:8] byte_index
  logic [1:0]          m_axis_tuser;        // [1:0] kind

  serial_frame_receiver_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [7:0]  rx_stream_q[$];       // bytes waiting to be sent
  sfr_res_t    deframed_exp_q[$];    // predicted results, oldest first
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;

  // parser shadow
  logic [7:0] sync_first  = HeaderFirstRst;
  logic [7:0] sync_second = HeaderSecondRst;
  parse_st_e  p_state = SEEK_SYNC0;
  logic [7:0] p_left  = '0;
  logic [7:0] p_sum   = '0;
  logic [7:0] p_pos   = '0;

  task automatic emit(input kind_e k, input logic [7:0] d, input logic [7:0] idx);
    sfr_res_t r;
    r.kind       = k;
    r.data_byte  = d;
    r.byte_index = idx;
    deframed_exp_q.push_back(r);
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    case (p_state)
      SEEK_SYNC1: begin
        if (b == sync_second) begin
          p_sum   = p_sum + b;
          p_state = TAKE_LEN;
        end else begin
          p_state = SEEK_SYNC0;   // mismatching byte is not retried as sync0
        end
      end
      TAKE_LEN: begin
        if (b < LenMin) begin
          emit(KIND_LENERR, b, 8'd0);
          p_state = SEEK_SYNC0;
        end else begin
          p_sum   = p_sum + b;
          p_left  = b - LenOverhead;
          p_pos   = '0;
          p_state = TAKE_BODY;
        end
      end
      TAKE_BODY: begin
        emit(KIND_PAYLOAD, b, p_pos);
        p_sum  = p_sum + b;
        p_pos  = p_pos + 8'd1;
        p_left = p_left - 8'd1;
        if (p_left == 0) p_state = TAKE_SUM;
      end
      TAKE_SUM: begin
        emit((b == p_sum) ? KIND_GOOD : KIND_BAD, b, 8'd0);
        p_state = SEEK_SYNC0;
      end
      default: begin
        if (b == sync_first) begin
          p_sum   = b;
          p_state = SEEK_SYNC1;
        end
      end
    endcase
  endtask

  // ---- source: bursts with random gaps --------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin : src_proc
    logic       nxt_valid;
    logic [7:0] nxt_data;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      nxt_valid = s_axis_tvalid;
      nxt_data  = s_axis_tdata;
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_byte(s_axis_tdata);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (rx_stream_q.size() != 0) begin
          nxt_valid = 1'b1;
          nxt_data  = rx_stream_q.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      s_axis_tvalid <= nxt_valid;
      s_axis_tdata  <= nxt_data;
    end
  end

  // ---- sink: stall pattern plus two long hold-offs ---------------------
  int unsigned results_seen = 0;
  int unsigned hold_left    = 0;
  int unsigned mode_timer   = 0;
  int unsigned stall_mode   = 0;

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : snk_proc
    sfr_res_t want;
    logic     rdy;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (deframed_exp_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual kind %0d data %0d index %0d",
                   $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8]);
          err_cnt++;
        end else begin
          want = deframed_exp_q.pop_front();
          check_field("kind", want.kind, m_axis_tuser);
          check_field("data_byte", want.data_byte, m_axis_tdata[7:0]);
          check_field("byte_index", want.byte_index, m_axis_tdata[15:8]);
        end
        if (results_seen == 150 || results_seen == 700) hold_left = LONG_HOLD;
      end
      if (mode_timer == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_timer = $urandom_range(16, 96);
      end else begin
        mode_timer--;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (stall_mode)
          0:       rdy = 1'b1;
          1:       rdy = ($urandom_range(0, 3) != 0);
          2:       rdy = ($urandom_range(0, 9) < 4);
          default: rdy = ~m_axis_tready;
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---- stimulus ----------------------------------------------------------
  task automatic queue_frame(input logic [7:0] len, input bit bad_sum, input int cut);
    logic [7:0] sum;
    logic [7:0] b;
    int         n;
    n   = int'(len) - int'(LenOverhead);
    sum = sync_first + sync_second + len;
    rx_stream_q.push_back(sync_first);
    rx_stream_q.push_back(sync_second);
    rx_stream_q.push_back(len);
    for (int i = 0; i < n; i++) begin
      if (cut != 0 && i == cut) return;
      b   = 8'($urandom);
      sum = sum + b;
      rx_stream_q.push_back(b);
    end
    if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
    rx_stream_q.push_back(sum);
  endtask

  task automatic queue_random_part(input int budget);
    int         pick;
    logic [7:0] len;
    logic [7:0] w;
    while (rx_stream_q.size() < budget) begin
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 99) == 0) ? 8'd255 : 8'($urandom_range(5, 24));
      if (pick < 70) begin
        queue_frame(len, 1'b0, 0);
      end else if (pick < 80) begin
        queue_frame(len, 1'b1, 0);
      end else if (pick < 86) begin
        // short length
        rx_stream_q.push_back(sync_first);
        rx_stream_q.push_back(sync_second);
        rx_stream_q.push_back(8'($urandom_range(0, 4)));
      end else if (pick < 92) begin
        // broken second sync byte
        if (sync_first != sync_second && $urandom_range(0, 1) == 1) begin
          w = sync_first;
        end else begin
          w = 8'($urandom);
          if (w == sync_second) w = w ^ 8'h01;
        end
        rx_stream_q.push_back(sync_first);
        rx_stream_q.push_back(w);
      end else if (pick < 96) begin
        len = 8'($urandom_range(6, 24));
        queue_frame(len, 1'b0, $urandom_range(1, int'(len) - 5));
      end else begin
        repeat ($urandom_range(1, 6)) rx_stream_q.push_back(8'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    // sample between edges so driver and monitor updates have settled
    do @(negedge clk_i);
    while (rx_stream_q.size() != 0 || s_axis_tvalid || deframed_exp_q.size() != 0);
    // last byte may be one that makes no result and still be in flight
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_sync(input logic [7:0] first, input logic [7:0] second);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_HEADER_FIRST;
    cfg_wdata_i <= first;
    @(posedge clk_i);
    cfg_addr_i  <= CFG_HEADER_SECOND;
    cfg_wdata_i <= second;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sync_first  = first;
    sync_second = second;
  endtask

  logic [7:0] opening [21];
  logic [7:0] sync_a  [4];
  logic [7:0] sync_b  [4];

  initial begin
    // minimal good frame; sync0 repeated where sync1 is due followed by a
    // zero that would read as a bad length if the repeat were taken as sync0;
    // lengths one below the limit and zero; bad checksum with 00/FF payload
    opening = '{8'hAA, 8'h55, 8'h05, 8'h00, 8'h04,
                8'hAA, 8'hAA, 8'h55, 8'h00,
                8'hAA, 8'h55, 8'h04,
                8'hAA, 8'h55, 8'h00,
                8'hAA, 8'h55, 8'h06, 8'hFF, 8'h00, 8'h03};
    sync_a = '{8'h00, 8'hFF, 8'h3C, 8'h00};
    sync_b = '{8'hFF, 8'h00, 8'h3C, 8'h00};
    sync_a[3] = 8'($urandom);
    sync_b[3] = 8'($urandom);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    foreach (opening[i]) rx_stream_q.push_back(opening[i]);
    queue_frame(8'd255, 1'b0, 0);     // longest payload, index up to 250
    queue_random_part(PHASE_BYTES);
    wait_drained();

    foreach (sync_a[i]) begin
      write_sync(sync_a[i], sync_b[i]);
      @(negedge clk_i);
      queue_random_part(PHASE_BYTES);
      wait_drained();
    end

    repeat (SETTLE_CYC) @(posedge clk_i);
    if (err_cnt == 0 && deframed_exp_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/sfr_pkg.sv
design/sfr_in_reg.sv
design/sfr_parser.sv
design/sfr_out_reg.sv
design/serial_frame_receiver_unit.sv
verif/tb.sv
